[rtl/bpc_pkg.sv]
// Types and constants shared by the button press classifier modules.
// Holds the item, result and configuration records and the action codes.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned BRIGHT_W = 8;
  localparam int unsigned LACT_W   = 3;
  localparam int unsigned RACT_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WINDOW = 2'd3;

  // Configuration reset values.
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 10'd33;
  localparam logic [THRESH_W-1:0] MEDIUM_PRESS_RST  = 16'd3000;
  localparam logic [THRESH_W-1:0] LONG_PRESS_RST    = 16'd8000;
  localparam logic [THRESH_W-1:0] SECOND_WINDOW_RST = 16'd2000;

  // Left button actions.
  localparam logic [LACT_W-1:0] LACT_NONE          = 3'd0;
  localparam logic [LACT_W-1:0] LACT_FACTORY_RESET = 3'd1;
  localparam logic [LACT_W-1:0] LACT_TOGGLE_WIFI   = 3'd2;
  localparam logic [LACT_W-1:0] LACT_STOP_RUNNING  = 3'd3;
  localparam logic [LACT_W-1:0] LACT_ABORT_SYNC    = 3'd4;
  localparam logic [LACT_W-1:0] LACT_BEGIN_SYNC    = 3'd5;
  localparam logic [LACT_W-1:0] LACT_START_RUNNING = 3'd6;

  // Right button actions.
  localparam logic [RACT_W-1:0] RACT_NONE       = 2'd0;
  localparam logic [RACT_W-1:0] RACT_ZERO_ANGLE = 2'd1;
  localparam logic [RACT_W-1:0] RACT_BRIGHTNESS = 2'd2;

  // Brightness stepping.
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX        = 8'd254;
  localparam logic [BRIGHT_W-1:0] BRIGHT_KNEE       = 8'd40;
  localparam logic [BRIGHT_W-1:0] BRIGHT_STEP_LOW   = 8'd8;
  localparam logic [BRIGHT_W-1:0] BRIGHT_STEP_HIGH  = 8'd25;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              left_pressed;
    logic              right_pressed;
    logic              clock_running;
    logic              sync_pending;
  } item_t;

  typedef struct packed {
    logic                sampled;
    logic [LACT_W-1:0]   left_action;
    logic [RACT_W-1:0]   right_action;
    logic [BRIGHT_W-1:0] brightness;
  } result_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] sample_period_ms;
    logic [THRESH_W-1:0] medium_press_ms;
    logic [THRESH_W-1:0] long_press_ms;
    logic [THRESH_W-1:0] second_press_window_ms;
  } cfg_t;

endpackage

[rtl/bpc_in_reg.sv]
// Input register stage of the button press classifier.
// Holds one accepted item until the evaluation stage takes it; uses bpc_pkg.
`timescale 1ns / 1ps

module bpc_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bpc_pkg::item_t in_item,
  input  logic           take,
  output logic           s1_valid,
  output bpc_pkg::item_t s1_item
);

  logic           valid_r;
  logic           valid_nxt;
  bpc_pkg::item_t item_r;

  assign in_ready = !valid_r || take;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/bpc_core.sv]
// Evaluation stage: sample gating, press tracking and press classification.
// Owns the classifier state and updates it when an item is taken; uses bpc_pkg.
`timescale 1ns / 1ps

module bpc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  bpc_pkg::item_t   item,
  input  bpc_pkg::cfg_t    cfg,
  output bpc_pkg::result_t result
);

  logic [bpc_pkg::TIME_W-1:0]   last_sample_r, last_sample_nxt;
  logic [bpc_pkg::TIME_W-1:0]   lstart_r, lstart_nxt;
  logic [bpc_pkg::TIME_W-1:0]   rstart_r, rstart_nxt;
  logic                         lheld_r, lheld_nxt;
  logic                         rheld_r, rheld_nxt;
  logic [bpc_pkg::TIME_W-1:0]   last_short_r, last_short_nxt;
  logic [bpc_pkg::BRIGHT_W-1:0] bright_r, bright_nxt;

  logic                         sample;
  logic [bpc_pkg::TIME_W-1:0]   since_sample;
  logic [bpc_pkg::TIME_W-1:0]   ldur;
  logic [bpc_pkg::TIME_W-1:0]   rdur;
  logic [bpc_pkg::TIME_W-1:0]   win_edge;
  logic                         fresh_press;
  logic [bpc_pkg::BRIGHT_W:0]   bright_sum;
  logic [bpc_pkg::BRIGHT_W-1:0] bright_step;
  logic [bpc_pkg::LACT_W-1:0]   lact;
  logic [bpc_pkg::RACT_W-1:0]   ract;

  assign since_sample = item.now_ms - last_sample_r;
  assign sample = since_sample >
                  {{(bpc_pkg::TIME_W-bpc_pkg::PERIOD_W){1'b0}}, cfg.sample_period_ms};
  assign ldur = item.now_ms - lstart_r;
  assign rdur = item.now_ms - rstart_r;
  assign win_edge = lstart_r -
                    {{(bpc_pkg::TIME_W-bpc_pkg::THRESH_W){1'b0}}, cfg.second_press_window_ms};
  // A press is a first press when it began outside the window after the last one.
  assign fresh_press = win_edge > last_short_r;

  // A full level wraps to zero; otherwise step and clamp at the maximum.
  always_comb begin
    bright_sum = {1'b0, bright_r} + {1'b0, bpc_pkg::BRIGHT_STEP_HIGH};
    if (bright_r < bpc_pkg::BRIGHT_KNEE) begin
      bright_sum = {1'b0, bright_r} + {1'b0, bpc_pkg::BRIGHT_STEP_LOW};
    end
    priority if (bright_r == bpc_pkg::BRIGHT_MAX) begin
      bright_step = '0;
    end else if (bright_sum > {1'b0, bpc_pkg::BRIGHT_MAX}) begin
      bright_step = bpc_pkg::BRIGHT_MAX;
    end else begin
      bright_step = bright_sum[bpc_pkg::BRIGHT_W-1:0];
    end
  end

  always_comb begin
    last_sample_nxt = last_sample_r;
    lstart_nxt      = lstart_r;
    rstart_nxt      = rstart_r;
    lheld_nxt       = lheld_r;
    rheld_nxt       = rheld_r;
    last_short_nxt  = last_short_r;
    bright_nxt      = bright_r;
    lact            = bpc_pkg::LACT_NONE;
    ract            = bpc_pkg::RACT_NONE;

    if (sample) begin
      last_sample_nxt = item.now_ms;

      if (item.left_pressed && !lheld_r) begin
        lheld_nxt  = 1'b1;
        lstart_nxt = item.now_ms;
      end else if (!item.left_pressed && lheld_r) begin
        lheld_nxt  = 1'b0;
        lstart_nxt = '0;
        priority if (ldur >=
            {{(bpc_pkg::TIME_W-bpc_pkg::THRESH_W){1'b0}}, cfg.long_press_ms}) begin
          lact = bpc_pkg::LACT_FACTORY_RESET;
        end else if (ldur >=
            {{(bpc_pkg::TIME_W-bpc_pkg::THRESH_W){1'b0}}, cfg.medium_press_ms}) begin
          lact = bpc_pkg::LACT_TOGGLE_WIFI;
        end else if (fresh_press) begin
          last_short_nxt = item.now_ms;
          priority if (item.clock_running) begin
            lact = bpc_pkg::LACT_STOP_RUNNING;
          end else if (item.sync_pending) begin
            lact = bpc_pkg::LACT_ABORT_SYNC;
          end else begin
            lact = bpc_pkg::LACT_BEGIN_SYNC;
          end
        end else if (item.sync_pending) begin
          lact = bpc_pkg::LACT_START_RUNNING;
        end else begin
          lact = bpc_pkg::LACT_NONE;
        end
      end

      if (item.right_pressed && !rheld_r) begin
        rheld_nxt  = 1'b1;
        rstart_nxt = item.now_ms;
      end else if (!item.right_pressed && rheld_r) begin
        rheld_nxt  = 1'b0;
        rstart_nxt = '0;
        if (rdur >= {{(bpc_pkg::TIME_W-bpc_pkg::THRESH_W){1'b0}}, cfg.medium_press_ms}) begin
          ract = bpc_pkg::RACT_ZERO_ANGLE;
        end else begin
          ract       = bpc_pkg::RACT_BRIGHTNESS;
          bright_nxt = bright_step;
        end
      end
    end
  end

  assign result.sampled      = sample;
  assign result.left_action  = lact;
  assign result.right_action = ract;
  assign result.brightness   = bright_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      lstart_r      <= '0;
      rstart_r      <= '0;
      lheld_r       <= 1'b0;
      rheld_r       <= 1'b0;
      last_short_r  <= '0;
      bright_r      <= '0;
    end else if (take) begin
      last_sample_r <= last_sample_nxt;
      lstart_r      <= lstart_nxt;
      rstart_r      <= rstart_nxt;
      lheld_r       <= lheld_nxt;
      rheld_r       <= rheld_nxt;
      last_short_r  <= last_short_nxt;
      bright_r      <= bright_nxt;
    end
  end

endmodule

[rtl/button_press_classifier_top.sv]
// Top level of the button press classifier: ports, configuration registers
// and result register. Uses bpc_pkg, bpc_in_reg and bpc_core.
//
//   Channel | Direction | Handshake         | Payload
//   in_     | slave     | tvalid / tready   | tdata: sample item (36 bits used of 40)
//   out_    | master    | tvalid / tready   | tdata: result item (14 bits used of 16)
//   cfg_    | write     | cfg_we            | cfg_index, cfg_wdata
//
// One item per clock cycle sustained while out_tready stays high. An input
// transfer loads the input register; when the result register is free or
// draining, the evaluation stage writes the result register and raises
// out_tvalid from that register.
// The evaluation stage updates the classifier state in the same cycle it
// writes the result register, so the next item always sees the new state.
// A stalled output holds its result while one more item waits in the input
// register. rst_n is synchronous and clears state, valids and configuration.
`timescale 1ns / 1ps

module button_press_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // now_ms[31:0], left_pressed[32], right_pressed[33], clock_running[34],
  // sync_pending[35], zero fill [39:36]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sampled[0], left_action[3:1], right_action[5:4], brightness[13:6],
  // zero fill [15:14]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  bpc_pkg::item_t   in_item;
  bpc_pkg::item_t   s1_item;
  logic             s1_valid;
  logic             take;
  bpc_pkg::result_t res;
  bpc_pkg::result_t res_r;
  logic             out_valid_r, out_valid_nxt;
  bpc_pkg::cfg_t    cfg_r;

  assign in_item.now_ms        = in_tdata[31:0];
  assign in_item.left_pressed  = in_tdata[32];
  assign in_item.right_pressed = in_tdata[33];
  assign in_item.clock_running = in_tdata[34];
  assign in_item.sync_pending  = in_tdata[35];

  // Take fires when an item waits and the result register is free or draining.
  assign take = s1_valid && (!out_valid_r || out_tready);

  bpc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  bpc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (s1_item),
    .cfg    (cfg_r),
    .result (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period_ms       <= bpc_pkg::SAMPLE_PERIOD_RST;
      cfg_r.medium_press_ms        <= bpc_pkg::MEDIUM_PRESS_RST;
      cfg_r.long_press_ms          <= bpc_pkg::LONG_PRESS_RST;
      cfg_r.second_press_window_ms <= bpc_pkg::SECOND_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_SAMPLE_PERIOD:
          cfg_r.sample_period_ms <= cfg_wdata[bpc_pkg::PERIOD_W-1:0];
        bpc_pkg::CFG_MEDIUM_PRESS:  cfg_r.medium_press_ms        <= cfg_wdata;
        bpc_pkg::CFG_LONG_PRESS:    cfg_r.long_press_ms          <= cfg_wdata;
        bpc_pkg::CFG_SECOND_WINDOW: cfg_r.second_press_window_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata[0]    = res_r.sampled;
  assign out_tdata[3:1]  = res_r.left_action;
  assign out_tdata[5:4]  = res_r.right_action;
  assign out_tdata[13:6] = res_r.brightness;
  assign out_tdata[15:14] = 2'b00;

endmodule

[tb/button_press_classifier_top_tb.sv]
// Self-checking testbench for button_press_classifier_top: a scoreboard class
// predicts each result from the accepted samples and checks the output stream.
// Depends on bpc_pkg and the button_press_classifier_top RTL.
`timescale 1ns / 1ps

module button_press_classifier_top_tb;

  localparam int TOTAL_ITEMS    = 1600;
  localparam int NUM_PHASES     = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  class bpc_scoreboard;
    logic [bpc_pkg::PERIOD_W-1:0] period;
    logic [bpc_pkg::THRESH_W-1:0] medium_ms;
    logic [bpc_pkg::THRESH_W-1:0] long_ms;
    logic [bpc_pkg::THRESH_W-1:0] window_ms;
    logic [bpc_pkg::TIME_W-1:0]   last_sample;
    logic [bpc_pkg::TIME_W-1:0]   last_short;
    logic [bpc_pkg::TIME_W-1:0]   press_t[2];
    bit                           held[2];
    logic [bpc_pkg::BRIGHT_W-1:0] level;
    bpc_pkg::result_t             predicted[$];
    int                           failures;
    int                           accepted;

    function new();
      period      = bpc_pkg::SAMPLE_PERIOD_RST;
      medium_ms   = bpc_pkg::MEDIUM_PRESS_RST;
      long_ms     = bpc_pkg::LONG_PRESS_RST;
      window_ms   = bpc_pkg::SECOND_WINDOW_RST;
      last_sample = '0;
      last_short  = '0;
      press_t     = '{default: '0};
      held        = '{default: 1'b0};
      level       = '0;
      failures    = 0;
      accepted    = 0;
    endfunction

    function void write_reg(logic [bpc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
        bpc_pkg::CFG_SAMPLE_PERIOD: period = value[bpc_pkg::PERIOD_W-1:0];
        bpc_pkg::CFG_MEDIUM_PRESS:  medium_ms = value;
        bpc_pkg::CFG_LONG_PRESS:    long_ms = value;
        bpc_pkg::CFG_SECOND_WINDOW: window_ms = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    // Works out the result of one accepted sample and queues it.
    function void note_sample(logic [39:0] d);
      logic [bpc_pkg::TIME_W-1:0] now;
      logic [1:0]                 lvl;
      logic                       run;
      logic                       sync;
      logic [bpc_pkg::TIME_W-1:0] start;
      logic [bpc_pkg::TIME_W-1:0] dur;
      bpc_pkg::result_t           r;
      now  = d[31:0];
      lvl  = d[33:32];
      run  = d[34];
      sync = d[35];
      accepted++;
      r = '0;
      r.left_action  = bpc_pkg::LACT_NONE;
      r.right_action = bpc_pkg::RACT_NONE;
      if ((now - last_sample) > {22'd0, period}) begin
        r.sampled = 1'b1;
        last_sample = now;
        for (int b = 0; b < 2; b++) begin
          if (lvl[b] && !held[b]) begin
            held[b]    = 1'b1;
            press_t[b] = now;
          end else if (!lvl[b] && held[b]) begin
            start      = press_t[b];
            held[b]    = 1'b0;
            press_t[b] = '0;
            dur        = now - start;
            if (b == 0) begin
              // The long check comes first, so a long threshold below the
              // medium one takes precedence.
              if (dur >= {16'd0, long_ms}) begin
                r.left_action = bpc_pkg::LACT_FACTORY_RESET;
              end else if (dur >= {16'd0, medium_ms}) begin
                r.left_action = bpc_pkg::LACT_TOGGLE_WIFI;
              end else if ((start - {16'd0, window_ms}) > last_short) begin
                last_short = now;
                if (run) r.left_action = bpc_pkg::LACT_STOP_RUNNING;
                else if (sync) r.left_action = bpc_pkg::LACT_ABORT_SYNC;
                else r.left_action = bpc_pkg::LACT_BEGIN_SYNC;
              end else begin
                r.left_action = sync ? bpc_pkg::LACT_START_RUNNING : bpc_pkg::LACT_NONE;
              end
            end else if (dur >= {16'd0, medium_ms}) begin
              r.right_action = bpc_pkg::RACT_ZERO_ANGLE;
            end else begin
              r.right_action = bpc_pkg::RACT_BRIGHTNESS;
              if (level == bpc_pkg::BRIGHT_MAX) level = '0;
              else if (level < bpc_pkg::BRIGHT_KNEE) level = level + bpc_pkg::BRIGHT_STEP_LOW;
              else if (level > bpc_pkg::BRIGHT_MAX - bpc_pkg::BRIGHT_STEP_HIGH)
                level = bpc_pkg::BRIGHT_MAX;
              else level = level + bpc_pkg::BRIGHT_STEP_HIGH;
            end
          end
        end
      end
      r.brightness = level;
      predicted.push_back(r);
    endfunction

    function void check_result(logic [15:0] d);
      bpc_pkg::result_t got;
      bpc_pkg::result_t want;
      got.sampled      = d[0];
      got.left_action  = d[3:1];
      got.right_action = d[5:4];
      got.brightness   = d[13:6];
      if (predicted.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing expected: sampled=%0d left=%0d right=%0d bright=%0d",
                   $time, got.sampled, got.left_action, got.right_action, got.brightness);
        return;
      end
      want = predicted.pop_front();
      if (got.sampled !== want.sampled || got.left_action !== want.left_action ||
          got.right_action !== want.right_action || got.brightness !== want.brightness) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: expected sampled=%0d left=%0d right=%0d bright=%0d, %s",
                   $time, want.sampled, want.left_action, want.right_action,
                   want.brightness,
                   $sformatf("got sampled=%0d left=%0d right=%0d bright=%0d",
                             got.sampled, got.left_action, got.right_action,
                             got.brightness));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // now_ms[31:0], left_pressed[32], right_pressed[33], clock_running[34],
  // sync_pending[35], zero fill [39:36]
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // sampled[0], left_action[3:1], right_action[5:4], brightness[13:6],
  // zero fill [15:14]
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  bpc_scoreboard              sb = new();
  logic [bpc_pkg::TIME_W-1:0] now_cursor;
  int                         tx_steady = 0;
  int                         rx_steady = 0;
  bit                         rx_hold_req = 1'b0;
  int                         quiet_cycles = 0;

  button_press_classifier_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic flip();
    return 1'($urandom_range(0, 1));
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int idle_len(inout int steady);
    int r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      steady = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bpc_pkg::TIME_W-1:0] pick_duration();
    logic [bpc_pkg::TIME_W-1:0] per;
    logic [bpc_pkg::TIME_W-1:0] med;
    logic [bpc_pkg::TIME_W-1:0] lng;
    logic [bpc_pkg::TIME_W-1:0] d;
    per = sb.period;
    med = sb.medium_ms;
    lng = sb.long_ms;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = per + 1 + $urandom_range(0, 300);
      4: d = med - 1;
      5: d = med;
      6: d = lng - 1;
      7: d = lng;
      8: d = $urandom_range(0, lng + lng / 2 + 1);
      default: d = med + $urandom_range(0, 2000);
    endcase
    if (d <= per) d = per + 1;
    return d;
  endfunction

  // Starts and ends at a falling edge; valid stays high between back-to-back items.
  task automatic send_sample(logic [bpc_pkg::TIME_W-1:0] now, logic l, r, run, sync);
    int gap;
    gap = idle_len(tx_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, sync, run, r, l, now};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_cfg(logic [bpc_pkg::PERIOD_W-1:0] per,
                             logic [bpc_pkg::THRESH_W-1:0] med, lng, win);
    logic [bpc_pkg::CFG_IDX_W-1:0] idx[4];
    logic [15:0]                   vals[4];
    idx  = '{bpc_pkg::CFG_SAMPLE_PERIOD, bpc_pkg::CFG_MEDIUM_PRESS,
             bpc_pkg::CFG_LONG_PRESS, bpc_pkg::CFG_SECOND_WINDOW};
    vals = '{{6'd0, per}, med, lng, win};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      sb.write_reg(idx[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // A press of one or both buttons, some unsampled chatter while held, then release.
  task automatic press_sequence();
    int                         which;
    int                         k;
    logic                       l;
    logic                       r;
    logic                       run;
    logic                       sync;
    logic [bpc_pkg::TIME_W-1:0] d;
    which = $urandom_range(0, 2);
    l = (which != 1);
    r = (which != 0);
    now_cursor += sb.period + 1 + $urandom_range(0, 50);
    send_sample(now_cursor, l, r, flip(), flip());
    k = $urandom_range(0, 2);
    repeat (k)
      send_sample(now_cursor + $urandom_range(0, sb.period), flip(), flip(), flip(), flip());
    d = pick_duration();
    now_cursor += d;
    run  = flip();
    sync = flip();
    send_sample(now_cursor, 1'b0, 1'b0, run, sync);
  endtask

  task automatic random_step();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      press_sequence();
    end else if (kind < 82) begin
      now_cursor = $urandom;
      send_sample(now_cursor, flip(), flip(), flip(), flip());
    end else if (kind < 95) begin
      now_cursor += sb.period + 1 + $urandom_range(0, 100);
      send_sample(now_cursor, 1'b0, 1'b0, flip(), flip());
    end else begin
      // Presses that straddle the wrap of the millisecond counter.
      now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      press_sequence();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("button_press_classifier_top_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        // Long hold-off so the block fills up and stalls its input.
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        n = idle_len(rx_steady);
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    int target;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Sample period boundary: a difference equal to the period is not sampled.
    send_sample(32'd33, 1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(32'd34, 1'b0, 1'b0, 1'b0, 1'b0);
    // A press that starts at time zero, reached through the counter wrap.
    send_sample(32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(32'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(32'd100, 1'b0, 1'b0, 1'b0, 1'b0);
    // Short left presses: first press with the clock running, then second
    // presses with and without a pending sync, then a first press to abort.
    send_sample(32'd10000, 1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(32'd10100, 1'b0, 1'b0, 1'b1, 1'b0);
    send_sample(32'd10200, 1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(32'd10300, 1'b0, 1'b0, 1'b0, 1'b1);
    send_sample(32'd10400, 1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(32'd10500, 1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(32'd20000, 1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(32'd20100, 1'b0, 1'b0, 1'b0, 1'b1);
    // Exactly medium on both buttons, exactly long on the left.
    send_sample(32'd30000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(32'd33000, 1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(32'd40000, 1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(32'd48000, 1'b0, 1'b0, 1'b0, 1'b0);
    // One below medium on both buttons at once.
    send_sample(32'd50000, 1'b1, 1'b1, 1'b1, 1'b1);
    send_sample(32'd52999, 1'b0, 1'b0, 1'b1, 1'b1);
    send_sample(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1, 1'b1);
    send_sample(32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0);
    now_cursor = 32'h5555_5555;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: program_cfg(bpc_pkg::SAMPLE_PERIOD_RST, bpc_pkg::MEDIUM_PRESS_RST,
                       bpc_pkg::LONG_PRESS_RST, bpc_pkg::SECOND_WINDOW_RST);
        1: program_cfg(10'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: program_cfg(10'd1000, 16'd0, 16'd0, 16'd0);
        3: program_cfg(10'd5, 16'd500, 16'd200, 16'd300);
        4: program_cfg(10'($urandom_range(1, 1000)), 16'($urandom_range(0, 5000)),
                       16'($urandom_range(0, 10000)), 16'($urandom_range(0, 4000)));
        default: program_cfg(bpc_pkg::SAMPLE_PERIOD_RST, bpc_pkg::MEDIUM_PRESS_RST,
                             bpc_pkg::LONG_PRESS_RST, bpc_pkg::SECOND_WINDOW_RST);
      endcase
      if (p == 4) rx_hold_req = 1'b1;
      target = (p + 1) * TOTAL_ITEMS / NUM_PHASES;
      while (sb.accepted < target) random_step();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("button_press_classifier_top_tb passed");
    end else begin
      $display("button_press_classifier_top_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bpc_pkg.sv
rtl/bpc_in_reg.sv
rtl/bpc_core.sv
rtl/button_press_classifier_top.sv
tb/button_press_classifier_top_tb.sv
